@@ src/segalloc_pkg.sv @@
// Shared types, codes and constants for the segment allocator.
package segalloc_pkg;

  localparam int MAX_SEGMENTS_DEF = 64;
  localparam int SIZE_W = 20;
  localparam int TIME_W = 32;
  localparam int ID_W = 16;
  localparam int CNT_OUT_W = 7;
  localparam int PCT_W = 7;
  localparam int DIV_NUM_W = 28;
  localparam int S_TDATA_W = 72;
  localparam int M_TDATA_W = 40;
  localparam logic [SIZE_W-1:0] MEM_RESET = 20'd1024;
  localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

  typedef enum logic [1:0] {
    KIND_ALLOC  = 2'd0,
    KIND_FINISH = 2'd1,
    KIND_EVICT  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FIT   = 2'd1,
    ST_NO_EVICT = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    OP_NOP, OP_INIT, OP_LOAD, OP_SHIFT, OP_WRITE, OP_OPEN, OP_DROP, OP_FINISH
  } cell_op_e;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_ACT1, S_ACT2, S_ACT3, S_DIV, S_WAIT
  } state_e;

  typedef struct packed {
    logic              valid;
    logic              hole;
    logic              fin;
    logic [SIZE_W-1:0] size;
    logic [TIME_W-1:0] stamp;
    logic [ID_W-1:0]   owner;
  } seg_t;

  typedef struct packed {
    cell_op_e        op;
    seg_t            wdata;
    logic [ID_W-1:0] id;
  } cell_cmd_t;

endpackage

@@ src/segalloc_cell.sv @@
// One segment slot of the table, with its neighbor shift paths and scan stage.
module segalloc_cell #(
  parameter int IdxW    = 6,
  parameter int CellIdx = 0
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  segalloc_pkg::cell_cmd_t cmd_i,
  input  logic [IdxW-1:0]        idx_i,
  input  segalloc_pkg::seg_t     left_i,
  input  segalloc_pkg::seg_t     right_i,
  input  segalloc_pkg::seg_t     scan_i,
  output segalloc_pkg::seg_t     seg_o,
  output segalloc_pkg::seg_t     scan_o
);

  localparam logic [IdxW-1:0] MyIdx = IdxW'(CellIdx);
  localparam segalloc_pkg::seg_t RstVal = (CellIdx == 0) ?
    segalloc_pkg::seg_t'{valid: 1'b1, hole: 1'b1, fin: 1'b0,
                         size: segalloc_pkg::MEM_RESET, stamp: '0, owner: '0} :
    segalloc_pkg::seg_t'('0);

  segalloc_pkg::seg_t main_q, main_d;
  segalloc_pkg::seg_t scan_q, scan_d;

  // Next value of the held segment for each broadcast command.
  always_comb begin
    main_d = main_q;
    case (cmd_i.op)
      segalloc_pkg::OP_INIT: begin
        main_d = (CellIdx == 0) ? cmd_i.wdata : segalloc_pkg::seg_t'('0);
      end
      segalloc_pkg::OP_WRITE: begin
        if (MyIdx == idx_i) main_d = cmd_i.wdata;
      end
      segalloc_pkg::OP_OPEN: begin
        if (MyIdx == idx_i) main_d = cmd_i.wdata;
        else if (MyIdx > idx_i) main_d = left_i;
      end
      segalloc_pkg::OP_DROP: begin
        if (MyIdx >= idx_i) main_d = right_i;
      end
      segalloc_pkg::OP_FINISH: begin
        if (main_q.valid && !main_q.hole && main_q.owner == cmd_i.id) main_d.fin = 1'b1;
      end
      default: ;
    endcase
  end

  // The scan stage copies the table, then streams it toward cell zero.
  always_comb begin
    scan_d = scan_q;
    case (cmd_i.op)
      segalloc_pkg::OP_LOAD:  scan_d = main_q;
      segalloc_pkg::OP_SHIFT: scan_d = scan_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_q <= RstVal;
    end else begin
      main_q <= main_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q <= scan_d;
  end

  assign seg_o  = main_q;
  assign scan_o = scan_q;

endmodule

@@ src/segalloc_div.sv @@
// Restoring divider, one quotient bit per cycle.
module segalloc_div #(
  parameter int NumW = 28,
  parameter int DenW = 20
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [NumW-1:0] quo_o
);

  localparam int CntW = $clog2(NumW + 1);

  logic            busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [NumW-1:0] num_q, quo_q;
  logic [DenW-1:0] den_q, rem_q;
  logic [DenW:0]   trial;
  logic            take;

  // Bring down the next numerator bit and try the subtraction.
  assign trial = {rem_q, num_q[NumW-1]};
  assign take  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      num_q  <= '0;
      quo_q  <= '0;
      den_q  <= '0;
      rem_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CntW'(NumW);
      num_q  <= num_i;
      den_q  <= den_i;
      rem_q  <= '0;
      quo_q  <= '0;
    end else if (busy_q) begin
      num_q  <= {num_q[NumW-2:0], 1'b0};
      quo_q  <= {quo_q[NumW-2:0], take};
      rem_q  <= take ? DenW'(trial - {1'b0, den_q}) : DenW'(trial);
      cnt_q  <= cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

@@ src/segment_allocator_with_eviction.sv @@
// Top level: segment table as a row of cells, sequencer and usage divider.
//
//  channel  direction  beat fields (lowest bits first)
//  cfg      in         cfg_data_i: memory_size
//  s_axis   in         tuser: kind; tdata: process_id, process_size, arrival_time
//  m_axis   out        tdata: status, evicted_id, process_count, hole_count,
//                      usage_percent
//
// An allocate or evict beat makes one pass of the scan chain through every cell,
// then the table edits (S_ACT1, and S_ACT2 and S_ACT3 where needed), then the
// usage divider. A finish beat or an unused kind skips the scan and the edits.
// After reset the table holds one hole of 1024 units; no clearing pass is needed.
// A result waiting on m_axis holds the next result back, not the next input beat.
module segment_allocator_with_eviction #(
  parameter int MAX_SEGMENTS = segalloc_pkg::MAX_SEGMENTS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [segalloc_pkg::SIZE_W-1:0]      cfg_data_i,    // memory_size
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // process_id[15:0], process_size[35:16], arrival_time[67:36], zero fill
  input  logic [segalloc_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  input  logic [1:0]                           s_axis_tuser,  // kind
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // status[1:0], evicted_id[17:2], process_count[24:18], hole_count[31:25],
  // usage_percent[38:32], zero fill
  output logic [segalloc_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

  localparam int IdxW = $clog2(MAX_SEGMENTS);
  localparam int CntW = $clog2(MAX_SEGMENTS + 1);
  localparam int SW   = segalloc_pkg::SIZE_W;
  localparam int NW   = segalloc_pkg::DIV_NUM_W;

  segalloc_pkg::seg_t      seg_w  [MAX_SEGMENTS];
  segalloc_pkg::seg_t      scan_w [MAX_SEGMENTS];
  segalloc_pkg::cell_cmd_t cmd;
  logic [IdxW-1:0]         cmd_idx;
  segalloc_pkg::seg_t      head;

  segalloc_pkg::state_e    state_q, state_d;
  logic [IdxW-1:0]         cnt_q, cnt_d;
  segalloc_pkg::kind_e     kind_q, kind_d;
  logic [15:0]             id_q, id_d;
  logic [SW-1:0]           size_q, size_d;
  logic [31:0]             stamp_q, stamp_d;
  logic [SW-1:0]           mem_q, mem_d, used_q, used_d;
  logic [CntW-1:0]         procs_q, procs_d, holes_q, holes_d, seg_cnt;
  segalloc_pkg::status_e   status_q, status_d;
  logic [15:0]             freed_q, freed_d;

  logic                    fit_q, fit_d;
  logic [IdxW-1:0]         fit_idx_q, fit_idx_d;
  logic [SW-1:0]           fit_size_q, fit_size_d;
  logic                    found_q, found_d, just_q, just_d;
  logic [IdxW-1:0]         best_idx_q, best_idx_d;
  logic [SW-1:0]           best_size_q, best_size_d;
  logic [31:0]             best_time_q, best_time_d;
  logic [15:0]             best_owner_q, best_owner_d;
  logic                    left_hole_q, left_hole_d, right_hole_q, right_hole_d;
  logic [SW-1:0]           left_size_q, left_size_d, right_size_q, right_size_d;
  logic                    prev_hole_q, prev_hole_d;
  logic [SW-1:0]           prev_size_q, prev_size_d;

  logic                    out_valid_q;
  logic [segalloc_pkg::M_TDATA_W-1:0] out_q;
  logic                    out_load;
  logic                    div_start, div_done;
  logic [NW-1:0]           div_quo, div_num;
  logic [segalloc_pkg::PCT_W-1:0] usage;
  logic                    s_acc, better;
  segalloc_pkg::seg_t      placed, hole_w;

  // Row of segment cells; each takes its neighbors' segments and the upper neighbor's scan stage.
  for (genvar k = 0; k < MAX_SEGMENTS; k++) begin : g_cell
    segalloc_pkg::seg_t left_s, right_s, scan_s;
    if (k == 0) begin : g_first
      assign left_s = '0;
    end else begin : g_mid
      assign left_s = seg_w[k-1];
    end
    if (k == MAX_SEGMENTS - 1) begin : g_last
      assign right_s = '0;
      assign scan_s  = '0;
    end else begin : g_inner
      assign right_s = seg_w[k+1];
      assign scan_s  = scan_w[k+1];
    end
    segalloc_cell #(.IdxW(IdxW), .CellIdx(k)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .idx_i   (cmd_idx),
      .left_i  (left_s),
      .right_i (right_s),
      .scan_i  (scan_s),
      .seg_o   (seg_w[k]),
      .scan_o  (scan_w[k])
    );
  end

  assign head    = scan_w[0];
  assign seg_cnt = procs_q + holes_q;
  assign s_acc   = s_axis_tvalid && s_axis_tready;
  assign placed  = '{valid: 1'b1, hole: 1'b0, fin: 1'b0, size: size_q,
                     stamp: stamp_q, owner: id_q};
  assign better  = !found_q || head.size > best_size_q ||
                   (head.size == best_size_q && head.stamp < best_time_q);

  // Usage ratio, rounded up: (used * 100 + size - 1) / size.
  assign div_num = NW'(used_q) * NW'(100) + NW'(mem_q) - NW'(1);

  segalloc_div #(.NumW(NW), .DenW(SW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (mem_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_comb begin
    if (mem_q == '0) usage = '0;
    else if (div_quo > NW'(segalloc_pkg::PCT_MAX)) usage = segalloc_pkg::PCT_MAX;
    else usage = div_quo[segalloc_pkg::PCT_W-1:0];
  end

  // Sequencer: idle (configuration or beat), scan pass, table edits, then the usage division.
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    kind_d       = kind_q;
    id_d         = id_q;
    size_d       = size_q;
    stamp_d      = stamp_q;
    mem_d        = mem_q;
    used_d       = used_q;
    procs_d      = procs_q;
    holes_d      = holes_q;
    status_d     = status_q;
    freed_d      = freed_q;
    fit_d        = fit_q;
    fit_idx_d    = fit_idx_q;
    fit_size_d   = fit_size_q;
    found_d      = found_q;
    just_d       = 1'b0;
    best_idx_d   = best_idx_q;
    best_size_d  = best_size_q;
    best_time_d  = best_time_q;
    best_owner_d = best_owner_q;
    left_hole_d  = left_hole_q;
    left_size_d  = left_size_q;
    right_hole_d = right_hole_q;
    right_size_d = right_size_q;
    prev_hole_d  = prev_hole_q;
    prev_size_d  = prev_size_q;
    cmd          = '{op: segalloc_pkg::OP_NOP, wdata: '0, id: '0};
    cmd_idx      = '0;
    hole_w       = '{valid: 1'b1, hole: 1'b1, fin: 1'b0, size: '0, stamp: '0, owner: '0};
    div_start    = 1'b0;
    out_load     = 1'b0;
    s_axis_tready = 1'b0;
    cfg_ready_o  = 1'b0;

    case (state_q)
      segalloc_pkg::S_IDLE: begin
        cfg_ready_o   = 1'b1;
        s_axis_tready = !cfg_valid_i;
        if (cfg_valid_i) begin
          // New memory size: the table becomes one hole of that size.
          hole_w.size = cfg_data_i;
          cmd.op      = segalloc_pkg::OP_INIT;
          cmd.wdata   = hole_w;
          mem_d       = cfg_data_i;
          used_d      = '0;
          procs_d     = '0;
          holes_d     = CntW'(1);
        end else if (s_acc) begin
          kind_d      = segalloc_pkg::kind_e'(s_axis_tuser);
          id_d        = s_axis_tdata[15:0];
          size_d      = s_axis_tdata[35:16];
          stamp_d     = s_axis_tdata[67:36];
          status_d    = segalloc_pkg::ST_OK;
          freed_d     = '0;
          cnt_d       = '0;
          fit_d       = 1'b0;
          found_d     = 1'b0;
          prev_hole_d = 1'b0;
          case (segalloc_pkg::kind_e'(s_axis_tuser))
            segalloc_pkg::KIND_ALLOC, segalloc_pkg::KIND_EVICT: begin
              cmd.op  = segalloc_pkg::OP_LOAD;
              state_d = segalloc_pkg::S_SCAN;
            end
            segalloc_pkg::KIND_FINISH: begin
              cmd.op  = segalloc_pkg::OP_FINISH;
              cmd.id  = s_axis_tdata[15:0];
              state_d = segalloc_pkg::S_DIV;
            end
            default: state_d = segalloc_pkg::S_DIV;
          endcase
        end
      end

      segalloc_pkg::S_SCAN: begin
        // The head of the scan chain is entry cnt_q of the table.
        cmd.op = segalloc_pkg::OP_SHIFT;
        if (kind_q == segalloc_pkg::KIND_ALLOC) begin
          if (head.valid && head.hole && head.size >= size_q) begin
            fit_d      = 1'b1;
            fit_idx_d  = cnt_q;
            fit_size_d = head.size;
          end
        end else begin
          if (head.valid && !head.hole && head.fin && better) begin
            found_d      = 1'b1;
            just_d       = 1'b1;
            best_idx_d   = cnt_q;
            best_size_d  = head.size;
            best_time_d  = head.stamp;
            best_owner_d = head.owner;
            left_hole_d  = prev_hole_q;
            left_size_d  = prev_size_q;
            right_hole_d = 1'b0;
          end else if (just_q) begin
            right_hole_d = head.valid && head.hole;
            right_size_d = head.size;
          end
          prev_hole_d = head.valid && head.hole;
          prev_size_d = head.size;
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == IdxW'(MAX_SEGMENTS - 1)) state_d = segalloc_pkg::S_ACT1;
      end

      segalloc_pkg::S_ACT1: begin
        state_d = segalloc_pkg::S_DIV;
        if (kind_q == segalloc_pkg::KIND_ALLOC) begin
          if (!fit_q) begin
            status_d = segalloc_pkg::ST_NO_FIT;
          end else if (fit_size_q == size_q) begin
            // Exact fit: the hole becomes the process.
            cmd.op    = segalloc_pkg::OP_WRITE;
            cmd_idx   = fit_idx_q;
            cmd.wdata = placed;
            holes_d   = holes_q - 1'b1;
            procs_d   = procs_q + 1'b1;
            used_d    = used_q + size_q;
          end else if (seg_cnt == CntW'(MAX_SEGMENTS)) begin
            status_d = segalloc_pkg::ST_FULL;
          end else begin
            // Split: shrink the hole, then open a slot above it.
            hole_w.size = fit_size_q - size_q;
            cmd.op      = segalloc_pkg::OP_WRITE;
            cmd_idx     = fit_idx_q;
            cmd.wdata   = hole_w;
            procs_d     = procs_q + 1'b1;
            used_d      = used_q + size_q;
            state_d     = segalloc_pkg::S_ACT2;
          end
        end else if (!found_q) begin
          status_d = segalloc_pkg::ST_NO_EVICT;
        end else begin
          freed_d = best_owner_q;
          used_d  = used_q - best_size_q;
          procs_d = procs_q - 1'b1;
          cmd.op  = segalloc_pkg::OP_WRITE;
          if (left_hole_q) begin
            // Merge into the hole below, taking the hole above along.
            hole_w.size = left_size_q + best_size_q +
                          (right_hole_q ? right_size_q : '0);
            cmd_idx = best_idx_q - 1'b1;
            holes_d = right_hole_q ? holes_q - 1'b1 : holes_q;
            state_d = segalloc_pkg::S_ACT2;
          end else begin
            hole_w.size = best_size_q + (right_hole_q ? right_size_q : '0);
            cmd_idx = best_idx_q;
            holes_d = right_hole_q ? holes_q : holes_q + 1'b1;
            if (right_hole_q) state_d = segalloc_pkg::S_ACT2;
          end
          cmd.wdata = hole_w;
        end
      end

      segalloc_pkg::S_ACT2: begin
        state_d = segalloc_pkg::S_DIV;
        if (kind_q == segalloc_pkg::KIND_ALLOC) begin
          cmd.op    = segalloc_pkg::OP_OPEN;
          cmd_idx   = fit_idx_q + 1'b1;
          cmd.wdata = placed;
        end else begin
          cmd.op = segalloc_pkg::OP_DROP;
          if (left_hole_q) begin
            cmd_idx = best_idx_q;
            if (right_hole_q) state_d = segalloc_pkg::S_ACT3;
          end else begin
            cmd_idx = best_idx_q + 1'b1;
          end
        end
      end

      segalloc_pkg::S_ACT3: begin
        // Holes on both sides: the old upper hole now sits at the same slot.
        cmd.op  = segalloc_pkg::OP_DROP;
        cmd_idx = best_idx_q;
        state_d = segalloc_pkg::S_DIV;
      end

      segalloc_pkg::S_DIV: begin
        div_start = 1'b1;
        state_d   = segalloc_pkg::S_WAIT;
      end

      segalloc_pkg::S_WAIT: begin
        if (div_done && (!out_valid_q || m_axis_tready)) begin
          out_load = 1'b1;
          state_d  = segalloc_pkg::S_IDLE;
        end
      end

      default: state_d = segalloc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= segalloc_pkg::S_IDLE;
      cnt_q        <= '0;
      kind_q       <= segalloc_pkg::KIND_ALLOC;
      id_q         <= '0;
      size_q       <= '0;
      stamp_q      <= '0;
      mem_q        <= segalloc_pkg::MEM_RESET;
      used_q       <= '0;
      procs_q      <= '0;
      holes_q      <= CntW'(1);
      status_q     <= segalloc_pkg::ST_OK;
      freed_q      <= '0;
      fit_q        <= 1'b0;
      fit_idx_q    <= '0;
      fit_size_q   <= '0;
      found_q      <= 1'b0;
      just_q       <= 1'b0;
      best_idx_q   <= '0;
      best_size_q  <= '0;
      best_time_q  <= '0;
      best_owner_q <= '0;
      left_hole_q  <= 1'b0;
      left_size_q  <= '0;
      right_hole_q <= 1'b0;
      right_size_q <= '0;
      prev_hole_q  <= 1'b0;
      prev_size_q  <= '0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      kind_q       <= kind_d;
      id_q         <= id_d;
      size_q       <= size_d;
      stamp_q      <= stamp_d;
      mem_q        <= mem_d;
      used_q       <= used_d;
      procs_q      <= procs_d;
      holes_q      <= holes_d;
      status_q     <= status_d;
      freed_q      <= freed_d;
      fit_q        <= fit_d;
      fit_idx_q    <= fit_idx_d;
      fit_size_q   <= fit_size_d;
      found_q      <= found_d;
      just_q       <= just_d;
      best_idx_q   <= best_idx_d;
      best_size_q  <= best_size_d;
      best_time_q  <= best_time_d;
      best_owner_q <= best_owner_d;
      left_hole_q  <= left_hole_d;
      left_size_q  <= left_size_d;
      right_hole_q <= right_hole_d;
      right_size_q <= right_size_d;
      prev_hole_q  <= prev_hole_d;
      prev_size_q  <= prev_size_d;
    end
  end

  // Output register for the result beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
      out_q       <= {1'b0, usage, holes_q[segalloc_pkg::CNT_OUT_W-1:0],
                      procs_q[segalloc_pkg::CNT_OUT_W-1:0], freed_q, status_q};
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule

@@ src/segalloc_checker.sv @@
// Port-level checks for the segment allocator, bound to the top level.
module segalloc_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               cfg_valid_i,
  input logic                               cfg_ready_o,
  input logic                               s_axis_tvalid,
  input logic                               s_axis_tready,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [segalloc_pkg::M_TDATA_W-1:0] m_axis_tdata
);

  // A stalled result beat keeps its data.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // One item at a time: no input beat is taken right after another.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready && !cfg_ready_o)
    else $error("input taken while an item is at work");

  // A configuration write leaves the block idle.
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |=> cfg_ready_o)
    else $error("block left idle after a configuration write");

  // Usage never exceeds one hundred percent.
  a_usage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[38:32] <= segalloc_pkg::PCT_MAX)
    else $error("usage above one hundred percent");

endmodule

bind segment_allocator_with_eviction segalloc_checker u_segalloc_checker (.*);

@@ tb/sv/segment_allocator_with_eviction_test.sv @@
// Self-checking testbench for the segment allocator with eviction.
module segment_allocator_with_eviction_test;
  import segalloc_pkg::*;

  localparam int NSEG = MAX_SEGMENTS_DEF;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 200;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ID_W-1:0]   pid;
    logic [SIZE_W-1:0] psize;
    logic [TIME_W-1:0] stamp;
  } job_t;

  // Highest field first, so that status lands in the lowest bits.
  typedef struct packed {
    logic [PCT_W-1:0]     usage;
    logic [CNT_OUT_W-1:0] holes;
    logic [CNT_OUT_W-1:0] procs;
    logic [ID_W-1:0]      evicted;
    logic [1:0]           status;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [SIZE_W-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;

  segment_allocator_with_eviction i_dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the segment table.
  logic [SIZE_W-1:0] mem_units;
  logic [SIZE_W-1:0] tbl_size[NSEG];
  logic              tbl_hole[NSEG];
  logic [TIME_W-1:0] tbl_stamp[NSEG];
  logic [ID_W-1:0]   tbl_owner[NSEG];
  logic              tbl_fin[NSEG];
  int                tbl_count;
  logic [SIZE_W-1:0] units_used;

  verdict_t pending_results[$];
  logic     pending_typed[$];
  verdict_t pending_typed_val[$];
  int errors = 0;
  int idle_cycles = 0;
  int results_seen = 0;
  int sender_idle_pct = 13;
  int receiver_idle_pct = 66;
  bit hold_receiver = 1'b0;
  int status_hits[4] = '{default: 0};

  function automatic void table_reset(logic [SIZE_W-1:0] units);
    mem_units = units;
    for (int k = 0; k < NSEG; k++) begin
      tbl_size[k] = '0; tbl_hole[k] = 1'b0; tbl_stamp[k] = '0;
      tbl_owner[k] = '0; tbl_fin[k] = 1'b0;
    end
    tbl_size[0] = units;
    tbl_hole[0] = 1'b1;
    tbl_count = 1;
    units_used = '0;
  endfunction

  function automatic void copy_slot(int dst, int src);
    tbl_size[dst] = tbl_size[src]; tbl_hole[dst] = tbl_hole[src];
    tbl_stamp[dst] = tbl_stamp[src]; tbl_owner[dst] = tbl_owner[src];
    tbl_fin[dst] = tbl_fin[src];
  endfunction

  function automatic void remove_slot(int i);
    for (int k = i; k + 1 < tbl_count; k++) copy_slot(k, k + 1);
    tbl_count--;
  endfunction

  // Applies one job to the shadow table and returns the expected result.
  function automatic verdict_t allocator_step(job_t j);
    verdict_t v;
    int hit;
    int np;
    int nh;
    logic [63:0] pct;
    v = '0;
    case (kind_e'(j.kind))
      KIND_ALLOC: begin
        v.status = ST_NO_FIT;
        for (int i = tbl_count - 1; i >= 0; i--) begin
          if (tbl_hole[i] && tbl_size[i] >= j.psize) begin
            if (tbl_size[i] == j.psize) begin
              hit = i;
            end else if (tbl_count >= NSEG) begin
              v.status = ST_FULL;
              break;
            end else begin
              for (int k = tbl_count; k > i + 1; k--) copy_slot(k, k - 1);
              tbl_count++;
              tbl_size[i] = tbl_size[i] - j.psize;
              hit = i + 1;
            end
            tbl_size[hit] = j.psize; tbl_hole[hit] = 1'b0; tbl_stamp[hit] = j.stamp;
            tbl_owner[hit] = j.pid; tbl_fin[hit] = 1'b0;
            units_used = units_used + j.psize;
            v.status = ST_OK;
            break;
          end
        end
      end
      KIND_FINISH: begin
        for (int i = 0; i < tbl_count; i++)
          if (!tbl_hole[i] && tbl_owner[i] == j.pid) tbl_fin[i] = 1'b1;
      end
      KIND_EVICT: begin
        hit = -1;
        for (int i = 0; i < tbl_count; i++) begin
          if (tbl_hole[i] || !tbl_fin[i]) continue;
          if (hit < 0 || tbl_size[i] > tbl_size[hit] ||
              (tbl_size[i] == tbl_size[hit] && tbl_stamp[i] < tbl_stamp[hit]))
            hit = i;
        end
        if (hit < 0) begin
          v.status = ST_NO_EVICT;
        end else begin
          v.evicted = tbl_owner[hit];
          units_used = units_used - tbl_size[hit];
          tbl_hole[hit] = 1'b1; tbl_fin[hit] = 1'b0;
          tbl_owner[hit] = '0; tbl_stamp[hit] = '0;
          if (hit + 1 < tbl_count && tbl_hole[hit + 1]) begin
            tbl_size[hit] = tbl_size[hit] + tbl_size[hit + 1];
            remove_slot(hit + 1);
          end
          if (hit > 0 && tbl_hole[hit - 1]) begin
            tbl_size[hit - 1] = tbl_size[hit - 1] + tbl_size[hit];
            remove_slot(hit);
          end
        end
      end
      default: ;
    endcase
    np = 0; nh = 0;
    for (int i = 0; i < tbl_count; i++)
      if (tbl_hole[i]) nh++; else np++;
    v.procs = np[CNT_OUT_W-1:0];
    v.holes = nh[CNT_OUT_W-1:0];
    if (mem_units != 0) begin
      pct = (64'(units_used) * 100 + mem_units - 1) / mem_units;
      if (pct > 100) pct = 100;
      v.usage = pct[PCT_W-1:0];
    end
    return v;
  endfunction

  // Sends one job; the expectation is queued as the beat is accepted.
  // The block is busy right after a beat, so the pause with valid low that follows costs nothing.
  task automatic offer_job(job_t j, bit typed, verdict_t typed_val);
    while ($urandom_range(99) < sender_idle_pct) @(posedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= j.kind;
    s_axis_tdata <= {4'b0, j.stamp, j.psize, j.pid};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(allocator_step(j));
    pending_typed.push_back(typed);
    pending_typed_val.push_back(typed_val);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_memory_size(logic [SIZE_W-1:0] units);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= units;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    table_reset(units);
  endtask

  function automatic job_t mk(logic [1:0] k, int pid, int sz, logic [31:0] t);
    job_t j;
    j.kind = k; j.pid = pid[ID_W-1:0]; j.psize = sz[SIZE_W-1:0]; j.stamp = t;
    return j;
  endfunction

  function automatic verdict_t vr(logic [1:0] st, int ev, int p, int h, int u);
    verdict_t v;
    v.status = st; v.evicted = ev[ID_W-1:0]; v.procs = p[CNT_OUT_W-1:0];
    v.holes = h[CNT_OUT_W-1:0]; v.usage = u[PCT_W-1:0];
    return v;
  endfunction

  // Random job biased toward useful sequences; sizes scale with memory.
  function automatic job_t random_job(int max_sz);
    job_t j;
    int r;
    r = $urandom_range(99);
    j.kind = (r < 50) ? KIND_ALLOC : (r < 72) ? KIND_FINISH : (r < 97) ? KIND_EVICT
             : KIND_NONE;
    j.pid = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(15));
    j.psize = ($urandom_range(19) == 0) ? 20'($urandom)
              : 20'($urandom_range(max_sz));
    j.stamp = ($urandom_range(3) == 0) ? 32'($urandom_range(7)) : 32'($urandom);
    return j;
  endfunction

  // Result beats are compared with the oldest expectation.
  always @(posedge clk_i) begin
    verdict_t got;
    verdict_t want;
    logic typed;
    verdict_t tv;
    if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[38:0];
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: %h", got);
        errors++;
      end else begin
        want = pending_results.pop_front();
        typed = pending_typed.pop_front();
        tv = pending_typed_val.pop_front();
        if (typed && tv != want) begin
          $error("directed row disagrees with predictor: %h vs %h", tv, want);
          errors++;
        end
        status_hits[got.status]++;
        if (got.status != want.status) begin
          $error("status expected %0d actual %0d", want.status, got.status); errors++;
        end
        if (got.evicted != want.evicted) begin
          $error("evicted_id expected %0d actual %0d", want.evicted, got.evicted);
          errors++;
        end
        if (got.procs != want.procs) begin
          $error("process_count expected %0d actual %0d", want.procs, got.procs);
          errors++;
        end
        if (got.holes != want.holes) begin
          $error("hole_count expected %0d actual %0d", want.holes, got.holes); errors++;
        end
        if (got.usage != want.usage) begin
          $error("usage_percent expected %0d actual %0d", want.usage, got.usage);
          errors++;
        end
      end
    end
  end

  // Receiver readiness, with an optional long hold-off.
  always @(posedge clk_i) begin
    m_axis_tready <= !hold_receiver && ($urandom_range(99) >= receiver_idle_pct);
  end

  // Watchdog on cycles with no accepted beat.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni || hold_receiver)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired");
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    job_t rows[$];
    logic typed_rows[$];
    verdict_t typed_vals[$];
    int mem_cfg;
    table_reset(MEM_RESET);
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows: expected values typed in where obvious.
    rows = '{mk(KIND_EVICT, 0, 0, 0), mk(KIND_NONE, 16'hffff, 20'hfffff, 32'hffffffff),
             mk(KIND_ALLOC, 1, 20'hfffff, 0), mk(KIND_ALLOC, 16'hffff, 1024, 32'hffffffff),
             mk(KIND_FINISH, 5, 0, 0), mk(KIND_FINISH, 16'hffff, 0, 0),
             mk(KIND_EVICT, 0, 0, 0), mk(KIND_ALLOC, 7, 0, 3),
             mk(KIND_ALLOC, 8, 100, 5), mk(KIND_ALLOC, 9, 100, 4),
             mk(KIND_ALLOC, 10, 1, 9), mk(KIND_FINISH, 8, 0, 0),
             mk(KIND_FINISH, 9, 0, 0), mk(KIND_FINISH, 10, 0, 0),
             mk(KIND_EVICT, 0, 0, 0), mk(KIND_EVICT, 0, 0, 0),
             mk(KIND_EVICT, 0, 0, 0), mk(KIND_EVICT, 0, 0, 0)};
    typed_rows = '{1, 1, 1, 1, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1};
    typed_vals = '{vr(ST_NO_EVICT, 0, 0, 1, 0), vr(ST_OK, 0, 0, 1, 0),
                   vr(ST_NO_FIT, 0, 0, 1, 0), vr(ST_OK, 0, 1, 0, 100),
                   vr(ST_OK, 0, 1, 0, 100), vr(ST_OK, 0, 1, 0, 100),
                   vr(ST_OK, 16'hffff, 0, 1, 0), '0, '0, '0, '0, '0, '0, '0,
                   '0, '0, '0, vr(ST_NO_EVICT, 0, 1, 1, 0)};
    foreach (rows[n]) offer_job(rows[n], typed_rows[n], typed_vals[n]);

    // Fill the table to its limit with one-unit blocks, then ask for a split it has no room for.
    write_memory_size(20'd200);
    for (int n = 0; n < NSEG; n++) offer_job(mk(KIND_ALLOC, n, 1, n), 0, '0);
    offer_job(mk(KIND_ALLOC, 99, 2, 0), 0, '0);

    // Random phases over several memory sizes, extremes included.
    for (int ph = 0; ph < 8; ph++) begin
      mem_cfg = (ph == 0) ? 1 : (ph == 1) ? 20'hfffff : (ph == 2) ? 0
                : $urandom_range(4096, 16);
      write_memory_size(mem_cfg[SIZE_W-1:0]);
      if (ph == 3) begin sender_idle_pct = 66; receiver_idle_pct = 13; end
      if (ph == 6) begin sender_idle_pct = 0; receiver_idle_pct = 0; end
      if (ph == 5) begin
        fork
          begin hold_receiver = 1'b1; repeat (3000) @(posedge clk_i); hold_receiver = 1'b0; end
        join_none
      end
      for (int n = 0; n < 120; n++)
        offer_job(random_job((mem_cfg < 8) ? 8 : mem_cfg / 6), 0, '0);
    end

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Covered %0d results across reset, extreme and random memory sizes.",
             results_seen);
    $display("Status counts ok/no-fit/no-evict/full: %0d/%0d/%0d/%0d",
             status_hits[0], status_hits[1], status_hits[2], status_hits[3]);
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end
endmodule

@@ filelist.f @@
src/segalloc_pkg.sv
src/segalloc_cell.sv
src/segalloc_div.sv
src/segment_allocator_with_eviction.sv
src/segalloc_checker.sv
tb/sv/segment_allocator_with_eviction_test.sv
